@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file, esbc_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ESBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ESBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Delayed implication, disabled while in reset.
`define ESBC_ASSERT_DLY2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/esbc_pkg.sv @@
// Package for the encoder-set blink counter: widths, reset values,
// register indexes and payload structs. No dependencies.
package esbc_pkg;

    localparam int COUNT_W  = 14;
    localparam int PERIOD_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COUNT_W;

    localparam logic [COUNT_W-1:0]  COUNT_LIMIT_RST = COUNT_W'(9999);
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = PERIOD_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_LIMIT  = 1'b0,
        CFG_BLINK_PERIOD = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count_limit;
        logic [PERIOD_W-1:0] blink_period_ticks;
    } cfg_t;

    typedef struct packed {
        logic clk_level;
        logic dt_level;
        logic button_level;
        logic tick;
    } in_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_value;
        logic               led_on;
        logic               blink_active;
    } out_req_t;

endpackage

@@ rtl/encoder_set_blink_counter_unit.sv @@
// Encoder-set blink counter, top level. A request is held in the input register,
// then its result is written to the result register.
// Throughput: one request per cycle while the output is not stalled, set by the
// single-pass state update between input and result registers.
// Reset (rst_n low, async): both stages empty, count 0, LED off, not
// blinking, count_limit 9999, blink_period_ticks 100. Depends on esbc_pkg, esbc_cfg, esbc_core.
module encoder_set_blink_counter_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [esbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [esbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  esbc_pkg::in_req_t                  in_req,
    // result output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output esbc_pkg::out_req_t                 out_req
);

    esbc_pkg::cfg_t     cfg;
    esbc_pkg::in_req_t  s1_req_reg;
    logic               s1_valid_reg;
    esbc_pkg::out_req_t result;
    esbc_pkg::out_req_t out_req_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_take;

    esbc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held request commits to state and result register together,
    // whenever the result register is empty or being drained.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    // Input register frees up in the same cycle it advances.
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    esbc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .req    (s1_req_reg),
        .cfg    (cfg),
        .result (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_req_reg <= in_req;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_req_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

endmodule

@@ rtl/esbc_cfg.sv @@
// Configuration register file for the blink counter.
// Depends on esbc_pkg.
module esbc_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [esbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [esbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output esbc_pkg::cfg_t                     cfg
);

    esbc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count_limit        <= esbc_pkg::COUNT_LIMIT_RST;
            cfg_reg.blink_period_ticks <= esbc_pkg::PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (esbc_pkg::cfg_idx_t'(cfg_index))
                esbc_pkg::CFG_COUNT_LIMIT:
                    cfg_reg.count_limit <= cfg_data[esbc_pkg::COUNT_W-1:0];
                esbc_pkg::CFG_BLINK_PERIOD:
                    cfg_reg.blink_period_ticks <= cfg_data[esbc_pkg::PERIOD_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/esbc_core.sv @@
// State registers and per-request update logic: encoder, button,
// blink check, prescaler. Depends on esbc_pkg.
module esbc_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  esbc_pkg::in_req_t   req,
    input  esbc_pkg::cfg_t      cfg,
    output esbc_pkg::out_req_t  result
);

    localparam int CW = esbc_pkg::COUNT_W;
    localparam int PW = esbc_pkg::PERIOD_W;

    logic          last_clock_reg, last_clock_next;
    logic          released_reg,   released_next;
    logic [CW-1:0] count_reg,      count_next;
    logic [PW-1:0] presc_reg,      presc_next;
    logic          blinking_reg,   blinking_next;
    logic          led_reg,        led_next;

    always_comb
    begin
        last_clock_next = last_clock_reg;
        released_next   = released_reg;
        count_next      = count_reg;
        presc_next      = presc_reg;
        blinking_next   = blinking_reg;
        led_next        = led_reg;

        // encoder: step on any clock change
        if (req.clk_level != last_clock_reg)
        begin
            last_clock_next = req.clk_level;
            if (req.dt_level == req.clk_level)
            begin
                if (count_reg != '0)
                    count_next = count_reg - CW'(1);
            end
            else if (count_reg < cfg.count_limit)
            begin
                count_next = count_reg + CW'(1);
            end
        end

        // button: falling edge starts a blink run if the count is nonzero
        if (req.button_level)
            released_next = 1'b1;
        if (released_next && !req.button_level)
        begin
            released_next = 1'b0;
            if (count_next != '0)
                blinking_next = 1'b1;
        end

        // blink: toggle at period, turn-off uses one count
        if (blinking_next && presc_reg == cfg.blink_period_ticks)
        begin
            presc_next = '0;
            led_next   = !led_reg;
            if (!led_next)
            begin
                if (count_next != '0)
                    count_next = count_next - CW'(1);
                if (count_next == '0)
                    blinking_next = 1'b0;
            end
        end

        if (req.tick)
            presc_next = presc_next + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clock_reg <= 1'b1;
            released_reg   <= 1'b1;
            count_reg      <= '0;
            presc_reg      <= '0;
            blinking_reg   <= 1'b0;
            led_reg        <= 1'b0;
        end
        else if (step)
        begin
            last_clock_reg <= last_clock_next;
            released_reg   <= released_next;
            count_reg      <= count_next;
            presc_reg      <= presc_next;
            blinking_reg   <= blinking_next;
            led_reg        <= led_next;
        end
    end

    assign result.count_value  = count_next;
    assign result.led_on       = led_next;
    assign result.blink_active = blinking_next;

endmodule

@@ rtl/esbc_checker.sv @@
// Port-level checker for the blink counter top level, with its bind.
// Depends on esbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module esbc_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input esbc_pkg::out_req_t  out_req
);

    // a stalled result holds
    `ESBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_req))

    // LED is lit only inside a blink run
    `ESBC_ASSERT_IMPL(a_led_in_run, clk, rst_n, out_valid && out_req.led_on, out_req.blink_active)

    // with the result register empty, requests are never stalled
    `ESBC_ASSERT_IMPL(a_no_false_stall, clk, rst_n, !out_valid, !in_stall)

    // an accepted request yields a result after the input and result registers
    `ESBC_ASSERT_DLY2(a_result_lat, clk, rst_n, in_valid && !in_stall, out_valid)

endmodule

bind encoder_set_blink_counter_unit esbc_checker u_esbc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
);
